[src/utf8v_pkg.sv]
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, widths and codes of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8v_pkg;

  // Position counter widths
  localparam int OFF_W = 32;
  localparam int COL_W = 31;

  // Depth of the queue between classifier and checker
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Fault / status codes
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_INVALID = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] FAULT_LIMIT   = 2'd3;

  // Sequence length codes from the lead byte; zero marks a bad lead
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  // Byte masks and bounds
  localparam logic [7:0] M_80 = 8'h80;
  localparam logic [7:0] M_C0 = 8'hC0;
  localparam logic [7:0] M_E0 = 8'hE0;
  localparam logic [7:0] M_F0 = 8'hF0;
  localparam logic [7:0] M_F8 = 8'hF8;
  localparam logic [7:0] M_1E = 8'h1E;
  localparam logic [7:0] M_0F = 8'h0F;
  localparam logic [7:0] M_20 = 8'h20;
  localparam logic [7:0] M_07 = 8'h07;
  localparam logic [7:0] M_30 = 8'h30;
  localparam logic [7:0] B_F4 = 8'hF4;
  localparam logic [7:0] B_8F = 8'h8F;

  // One classified byte as held in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
    logic [2:0] lead_len;   // length if taken as a lead byte
    logic       lead_bad;   // overlong C0/C1 or lead above F4
    logic       is_cont;    // 10xxxxxx
  } item_t;

endpackage

`default_nettype wire

[src/utf8v_in_if.sv]
// ----------------------------------------------------------------------------
// utf8v_in_if
// Byte channel: one text byte and its end-of-chunk flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

`default_nettype wire

[src/utf8v_out_if.sv]
// ----------------------------------------------------------------------------
// utf8v_out_if
// Result channel: chunk status and position per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] offset_out;
  logic [30:0] column_out;

  modport source (output valid, output status, output offset_out, output column_out,
                  input ready);
  modport sink   (input valid, input status, input offset_out, input column_out,
                  output ready);
endinterface

`default_nettype wire

[src/utf8v_cfg_if.sv]
// ----------------------------------------------------------------------------
// utf8v_cfg_if
// Configuration write channel for the validate_enable register.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/utf8v_front.sv]
// ----------------------------------------------------------------------------
// utf8v_front
// Accepts byte beats and classifies each byte before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_front (
  utf8v_in_if.sink           in_bus,
  input  wire logic          q_full,
  output logic               push,
  output utf8v_pkg::item_t   push_item
);
  import utf8v_pkg::*;

  logic [7:0] b;
  logic [2:0] len;

  assign b = in_bus.data_byte;

  // Lead byte length
  always_comb begin
    if ((b & M_80) == 8'h00)      len = LEN_1;
    else if ((b & M_E0) == M_C0)  len = LEN_2;
    else if ((b & M_F0) == M_E0)  len = LEN_3;
    else if ((b & M_F8) == M_F0)  len = LEN_4;
    else                          len = LEN_BAD;
  end

  assign in_bus.ready = !q_full;
  assign push         = in_bus.valid && !q_full;

  always_comb begin
    push_item.data_byte = b;
    push_item.chunk_end = in_bus.chunk_end;
    push_item.lead_len  = len;
    // overlong two-byte lead, or four-byte lead beyond U+10FFFF range
    push_item.lead_bad  = ((len == LEN_2) && ((b & M_1E) == 8'h00)) ||
                          ((len == LEN_4) && (b > B_F4));
    push_item.is_cont   = ((b & M_C0) == M_80);
  end

endmodule

`default_nettype wire

[src/utf8v_queue.sv]
// ----------------------------------------------------------------------------
// utf8v_queue
// Small FIFO of classified bytes between the front and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire utf8v_pkg::item_t   push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output utf8v_pkg::item_t        head_item
);
  import utf8v_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_pop;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[src/utf8v_back.sv]
// ----------------------------------------------------------------------------
// utf8v_back
// Sequence checker: tracks the open sequence, faults and position counters,
// and registers one result beat at each chunk end.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire utf8v_pkg::item_t   head_item,
  output logic                    pop,
  utf8v_cfg_if.sink               cfg_bus,
  utf8v_out_if.source             out_bus
);
  import utf8v_pkg::*;

  logic             ven_r;
  logic [1:0]       pend_r, pend_nxt;
  logic [2:0]       seq_r, seq_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [1:0]       fault_r, fault_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [OFF_W-1:0] out_off_r;
  logic [COL_W-1:0] out_col_r;
  logic [1:0]       res_status;

  logic [2:0]       adv_len;
  logic [OFF_W:0]   off_sum;
  logic [COL_W:0]   col_sum;
  logic             off_ovf, col_ovf;
  logic [1:0]       adv_of;
  logic [1:0]       adv_res;
  logic             adv_take;
  logic [1:0]       f_c;
  logic [1:0]       pend_c;
  logic             second;
  logic [7:0]       b;

  assign b = head_item.data_byte;

  // Take a byte unless a result would be blocked
  assign pop = head_valid &&
               (!head_item.chunk_end || !out_valid_r || out_bus.ready);

  // Shared position adder: one byte, or the whole sequence at its last byte
  assign adv_len = (ven_r && (pend_r != 2'd0)) ? seq_r : LEN_1;
  assign off_sum = {1'b0, off_r} + (OFF_W+1)'(adv_len);
  assign col_sum = {1'b0, col_r} + (COL_W+1)'(adv_len);
  assign off_ovf = off_sum[OFF_W];
  assign col_ovf = col_sum[COL_W];
  assign adv_of  = ven_r ? FAULT_INVALID : FAULT_LIMIT;
  assign adv_res = off_ovf ? adv_of : (col_ovf ? FAULT_LIMIT : FAULT_NONE);

  // Continuation checks
  assign second = (({1'b0, pend_r} + 3'd1) == seq_r);
  assign pend_c = pend_r - 2'd1;
  always_comb begin
    f_c = fault_r;
    if (fault_r == FAULT_NONE) begin
      if (!head_item.is_cont) begin
        f_c = FAULT_INVALID;
      end else if (second) begin
        if ((seq_r == LEN_3) && ((lead_r & M_0F) == 8'h00) && ((b & M_20) == 8'h00))
          f_c = FAULT_INVALID;
        if ((seq_r == LEN_4) && ((lead_r & M_07) == 8'h00) && ((b & M_30) == 8'h00))
          f_c = FAULT_INVALID;
        if ((seq_r == LEN_4) && (lead_r == B_F4) && (b > B_8F))
          f_c = FAULT_INVALID;
      end
    end
  end

  // Next state for the byte at the queue head
  always_comb begin
    pend_nxt  = pend_r;
    seq_nxt   = seq_r;
    lead_nxt  = lead_r;
    fault_nxt = fault_r;
    adv_take  = 1'b0;
    if (!ven_r) begin
      pend_nxt = 2'd0;
      seq_nxt  = 3'd0;
      adv_take = (fault_r == FAULT_NONE);
    end else if (pend_r != 2'd0) begin
      pend_nxt  = pend_c;
      fault_nxt = f_c;
      adv_take  = (pend_c == 2'd0) && (f_c == FAULT_NONE);
    end else if (fault_r == FAULT_NONE) begin
      case (head_item.lead_len)
        LEN_BAD: fault_nxt = FAULT_INVALID;
        LEN_1:   adv_take  = 1'b1;
        default: begin
          lead_nxt = b;
          seq_nxt  = head_item.lead_len;
          pend_nxt = 2'(head_item.lead_len - 3'd1);
          if (head_item.lead_bad) fault_nxt = FAULT_INVALID;
        end
      endcase
    end
    if (adv_take) begin
      fault_nxt = adv_res;
    end
  end

  assign off_nxt    = (adv_take && (adv_res == FAULT_NONE)) ? off_sum[OFF_W-1:0] : off_r;
  assign col_nxt    = (adv_take && (adv_res == FAULT_NONE)) ? col_sum[COL_W-1:0] : col_r;
  assign res_status = (pend_nxt != 2'd0) ? ST_INCOMPLETE : fault_nxt;

  // Sequence state; chunk end clears all but the position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      seq_r   <= 3'd0;
      lead_r  <= 8'h00;
      fault_r <= FAULT_NONE;
      off_r   <= '0;
      col_r   <= COL_W'(1);
    end else if (pop) begin
      off_r <= off_nxt;
      col_r <= col_nxt;
      if (head_item.chunk_end) begin
        pend_r  <= 2'd0;
        seq_r   <= 3'd0;
        lead_r  <= 8'h00;
        fault_r <= FAULT_NONE;
      end else begin
        pend_r  <= pend_nxt;
        seq_r   <= seq_nxt;
        lead_r  <= lead_nxt;
        fault_r <= fault_nxt;
      end
    end
  end

  // Configuration register
  assign cfg_bus.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ven_r <= 1'b1;
    end else if (cfg_bus.valid) begin
      ven_r <= cfg_bus.data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head_item.chunk_end) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.chunk_end) begin
      out_status_r <= res_status;
      out_off_r    <= off_nxt;
      out_col_r    <= col_nxt;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.offset_out = out_off_r;
  assign out_bus.column_out = out_col_r;

endmodule

`default_nettype wire

[src/utf8_stream_validator.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator
// A chunk's last byte passes the byte queue; its result is then registered.
// Throughput: one byte per cycle, set by the sequence checker, while no chunk
// end waits on a held result; a four-entry queue parts byte intake from that stall.
// Reset (rst_n low, synchronous): queue empty, no result pending, offset 0,
// column 1, validation enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator (
  input  wire logic    clk,
  input  wire logic    rst_n,
  utf8v_in_if.sink     in_bus,
  utf8v_out_if.source  out_bus,
  utf8v_cfg_if.sink    cfg_bus
);
  import utf8v_pkg::*;

  logic  push, q_full, pop, head_valid;
  item_t push_item, head_item;

  // Intake and classification
  utf8v_front u_front (
    .in_bus    (in_bus),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Byte queue
  utf8v_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Sequence checker and result
  utf8v_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .cfg_bus    (cfg_bus),
    .out_bus    (out_bus)
  );

endmodule

`default_nettype wire

[test/utf8_stream_validator_tb.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator_tb
// Self-checking bench for the UTF-8 stream validator. A directed table covers
// lead and continuation extremes, overlong and out-of-range forms, surrogates,
// cut-off sequences and a mid-sequence switch of validation; random chunks of
// mostly well-formed sequences follow under alternating validation settings.
// Every result beat is checked against the directed table or an in-bench model.
// ----------------------------------------------------------------------------
module utf8_stream_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8v_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int BYTES_PER_PHASE = 200;
  localparam int NUM_PHASES      = 5;
  localparam bit [NUM_PHASES-1:0] PHASE_CHECK = 5'b10101;

  localparam longint unsigned OFFSET_LIMIT = (64'd1 << OFF_W) - 1;
  localparam longint unsigned COLUMN_LIMIT = (64'd1 << COL_W) - 1;

  typedef enum logic [1:0] {CFG_KEEP, CFG_SET_OFF, CFG_SET_ON} cfg_step_e;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] offset;
    logic [COL_W-1:0] column;
  } chunk_result_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             typed;
    logic [1:0]       status;
    logic [OFF_W-1:0] offset;
    logic [COL_W-1:0] column;
    cfg_step_e        cfg;
  } dir_row_t;

  logic clk;
  logic rst_n;

  utf8v_in_if  in_if ();
  utf8v_out_if out_if ();
  utf8v_cfg_if cfg_if ();

  utf8_stream_validator u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // Model state: configuration, open sequence, chunk fault, position
  bit               check_on;
  logic [1:0]       pend;
  logic [2:0]       seq_len;
  logic [7:0]       seq_lead;
  logic [1:0]       chunk_fault;
  longint unsigned  pos_offset;
  longint unsigned  pos_column;

  chunk_result_t chunk_results_due[$];
  dir_row_t      directed_rows[$];
  logic [7:0]    chunk_bytes[$];

  int cycle_count;
  int mismatch_count;
  bit steady_flow;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- model --

  function automatic logic [1:0] bump_position(int unsigned len, logic [1:0] offset_fault);
    if (pos_offset > OFFSET_LIMIT - len) return offset_fault;
    if (pos_column > COLUMN_LIMIT - len) return FAULT_LIMIT;
    pos_offset += len;
    pos_column += len;
    return FAULT_NONE;
  endfunction

  task automatic reset_model();
    check_on    = 1'b1;
    pend        = 2'd0;
    seq_len     = 3'd0;
    seq_lead    = 8'd0;
    chunk_fault = FAULT_NONE;
    pos_offset  = 0;
    pos_column  = 1;
  endtask

  // Lead byte: length from the top bits, bad leads and C0/C1, F5..F7 flagged
  task automatic model_lead(logic [7:0] b);
    logic [2:0] len;
    if ((b & M_80) == 8'd0) len = LEN_1;
    else if ((b & M_E0) == M_C0) len = LEN_2;
    else if ((b & M_F0) == M_E0) len = LEN_3;
    else if ((b & M_F8) == M_F0) len = LEN_4;
    else len = LEN_BAD;

    if (len == LEN_BAD) begin
      chunk_fault = FAULT_INVALID;
    end else if (len == LEN_1) begin
      chunk_fault = bump_position(1, FAULT_INVALID);
    end else begin
      seq_lead = b;
      seq_len  = len;
      pend     = len[1:0] - 2'd1;
      if (len == LEN_2 && (b & M_1E) == 8'd0) chunk_fault = FAULT_INVALID;
      if (len == LEN_4 && b > B_F4) chunk_fault = FAULT_INVALID;
    end
  endtask

  // Continuation byte: shape, then overlong / range bounds on the second byte
  task automatic model_cont(logic [7:0] b);
    bit second;
    second = ({1'b0, pend} + 3'd1 == seq_len);
    if (chunk_fault == FAULT_NONE) begin
      if ((b & M_C0) != M_80) begin
        chunk_fault = FAULT_INVALID;
      end else if (second) begin
        if (seq_len == LEN_3 && (seq_lead & M_0F) == 8'd0 && (b & M_20) == 8'd0)
          chunk_fault = FAULT_INVALID;
        if (seq_len == LEN_4) begin
          if ((seq_lead & M_07) == 8'd0 && (b & M_30) == 8'd0) chunk_fault = FAULT_INVALID;
          if (seq_lead == B_F4 && b > B_8F) chunk_fault = FAULT_INVALID;
        end
      end
    end
    pend = pend - 2'd1;
    if (pend == 2'd0 && chunk_fault == FAULT_NONE)
      chunk_fault = bump_position(32'(seq_len), FAULT_INVALID);
  endtask

  // One accepted byte; on chunk end the result is queued when keep is set
  task automatic predict_byte(logic [7:0] b, bit last, bit keep);
    chunk_result_t r;
    if (!check_on) begin
      pend    = 2'd0;
      seq_len = 3'd0;
      if (chunk_fault == FAULT_NONE) chunk_fault = bump_position(1, FAULT_LIMIT);
    end else if (pend != 2'd0) begin
      model_cont(b);
    end else if (chunk_fault == FAULT_NONE) begin
      model_lead(b);
    end

    if (last) begin
      r.status = (pend != 2'd0) ? ST_INCOMPLETE : chunk_fault;
      r.offset = pos_offset[OFF_W-1:0];
      r.column = pos_column[COL_W-1:0];
      if (keep) chunk_results_due.push_back(r);
      pend        = 2'd0;
      seq_len     = 3'd0;
      seq_lead    = 8'd0;
      chunk_fault = FAULT_NONE;
    end
  endtask

  // -------------------------------------------------------------- drivers --

  // One byte beat, with a random gap ahead of it unless the flow is steady
  task automatic send_byte(logic [7:0] b, bit last, bit keep);
    if (!steady_flow && $urandom_range(99, 0) < 24) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < 24);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.chunk_end <= last;
    do @(posedge clk); while (!in_if.ready);
    predict_byte(b, last, keep);
  endtask

  // Hold the byte channel until all results are in and the queue has drained
  task automatic settle();
    in_if.valid <= 1'b0;
    while (chunk_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_validation(bit on);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= on;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    check_on = on;
  endtask

  // Result side: check each beat, then draw ready for the next cycle
  always @(posedge clk) begin
    chunk_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (chunk_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, status %0d", out_if.status));
      end else begin
        want = chunk_results_due.pop_front();
        if (out_if.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_if.status, want.status));
        if (out_if.offset_out !== want.offset)
          report_mismatch($sformatf("offset got %0d want %0d", out_if.offset_out,
                                    want.offset));
        if (out_if.column_out !== want.column)
          report_mismatch($sformatf("column got %0d want %0d", out_if.column_out,
                                    want.column));
      end
    end
    out_if.ready <= steady_flow || ($urandom_range(99, 0) >= 24);
  end

  // ------------------------------------------------------------- stimulus --

  function automatic logic [7:0] rand_byte(logic [7:0] lo, logic [7:0] hi);
    int unsigned r;
    r = $urandom_range(32'(hi), 32'(lo));
    return r[7:0];
  endfunction

  task automatic add_row(logic [7:0] data, bit last, cfg_step_e cfg);
    dir_row_t row;
    row        = '0;
    row.data   = data;
    row.last   = last;
    row.cfg    = cfg;
    directed_rows.push_back(row);
  endtask

  task automatic add_checked_row(logic [7:0] data, logic [1:0] status,
                                 logic [OFF_W-1:0] offset, logic [COL_W-1:0] column);
    dir_row_t row;
    row        = '0;
    row.data   = data;
    row.last   = 1'b1;
    row.typed  = 1'b1;
    row.status = status;
    row.offset = offset;
    row.column = column;
    row.cfg    = CFG_KEEP;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    // ASCII extremes right after reset
    add_checked_row(8'h00, FAULT_NONE, 1, 2);
    add_checked_row(8'h7F, FAULT_NONE, 2, 3);
    // bad lead byte
    add_checked_row(8'hFF, FAULT_INVALID, 2, 3);
    // lone continuation, then a sticky fault swallows the ASCII byte
    add_row(8'h80, 1'b0, CFG_KEEP);
    add_checked_row(8'h41, FAULT_INVALID, 2, 3);
    // overlong two-byte lead, fault kept while the sequence counts down
    add_row(8'hC0, 1'b0, CFG_KEEP);
    add_row(8'h80, 1'b1, CFG_KEEP);
    // overlong three-byte form at its upper edge
    add_row(8'hE0, 1'b0, CFG_KEEP);
    add_row(8'h9F, 1'b0, CFG_KEEP);
    add_row(8'hBF, 1'b1, CFG_KEEP);
    // just above U+10FFFF
    add_row(8'hF4, 1'b0, CFG_KEEP);
    add_row(8'h90, 1'b0, CFG_KEEP);
    add_row(8'h80, 1'b0, CFG_KEEP);
    add_row(8'h80, 1'b1, CFG_KEEP);
    // U+10FFFF itself
    add_row(8'hF4, 1'b0, CFG_KEEP);
    add_row(8'h8F, 1'b0, CFG_KEEP);
    add_row(8'hBF, 1'b0, CFG_KEEP);
    add_row(8'hBF, 1'b1, CFG_KEEP);
    // surrogate is accepted
    add_row(8'hED, 1'b0, CFG_KEEP);
    add_row(8'hA0, 1'b0, CFG_KEEP);
    add_row(8'h80, 1'b1, CFG_KEEP);
    // continuation expected, ASCII found
    add_row(8'hC3, 1'b0, CFG_KEEP);
    add_row(8'h41, 1'b1, CFG_KEEP);
    // sequence cut off by the chunk end
    add_row(8'hE2, 1'b0, CFG_KEEP);
    add_checked_row(8'h82, ST_INCOMPLETE, 9, 10);
    // validation switched off with a sequence open
    add_row(8'hE2, 1'b0, CFG_KEEP);
    add_row(8'h41, 1'b1, CFG_SET_OFF);
  endtask

  // Well-formed sequence of random length and content
  task automatic add_valid_seq();
    int         len;
    logic [7:0] lead;
    len = $urandom_range(4, 1);
    case (len)
      1: chunk_bytes.push_back(rand_byte(8'h00, 8'h7F));
      2: begin
        chunk_bytes.push_back(rand_byte(8'hC2, 8'hDF));
        chunk_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end
      3: begin
        lead = rand_byte(8'hE0, 8'hEF);
        chunk_bytes.push_back(lead);
        chunk_bytes.push_back(rand_byte(lead == 8'hE0 ? 8'hA0 : 8'h80, 8'hBF));
        chunk_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end
      default: begin
        lead = rand_byte(8'hF0, 8'hF4);
        chunk_bytes.push_back(lead);
        if (lead == 8'hF0) chunk_bytes.push_back(rand_byte(8'h90, 8'hBF));
        else if (lead == 8'hF4) chunk_bytes.push_back(rand_byte(8'h80, 8'h8F));
        else chunk_bytes.push_back(rand_byte(8'h80, 8'hBF));
        chunk_bytes.push_back(rand_byte(8'h80, 8'hBF));
        chunk_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end
    endcase
  endtask

  // Chunk of 1..6 sequences: mostly valid, some noise, some with one byte
  // corrupted, and now and then the last sequence cut short
  task automatic build_chunk();
    int n_seq;
    int start;
    int kind;
    int idx;
    int cut;
    chunk_bytes.delete();
    start = 0;
    n_seq = $urandom_range(6, 1);
    for (int s = 0; s < n_seq; s++) begin
      start = chunk_bytes.size();
      kind  = $urandom_range(99, 0);
      if (kind < 15) begin
        chunk_bytes.push_back(rand_byte(8'h00, 8'hFF));
      end else begin
        add_valid_seq();
        if (kind < 30) begin
          idx = $urandom_range(chunk_bytes.size() - 1, start);
          chunk_bytes[idx] = rand_byte(8'h00, 8'hFF);
        end
      end
    end
    if ($urandom_range(99, 0) < 15 && chunk_bytes.size() - start > 1) begin
      cut = $urandom_range(chunk_bytes.size() - start - 1, 1);
      repeat (cut) void'(chunk_bytes.pop_back());
    end
  endtask

  // ----------------------------------------------------------------- main --
  initial begin
    dir_row_t row;
    int       sent;

    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'd0;
    in_if.chunk_end = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = 1'b0;
    out_if.ready    = 1'b0;
    mismatch_count  = 0;
    steady_flow     = 1'b0;
    reset_model();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    build_directed();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.cfg != CFG_KEEP) begin
        settle();
        set_validation(row.cfg == CFG_SET_ON);
      end
      send_byte(row.data, row.last, !row.typed);
      if (row.typed) chunk_results_due.push_back({row.status, row.offset, row.column});
    end

    // Random phases, validation alternating; the middle one runs without gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_validation(PHASE_CHECK[p]);
      steady_flow = (p == 2);
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        build_chunk();
        foreach (chunk_bytes[i])
          send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1, 1'b1);
        sent += chunk_bytes.size();
      end
    end

    steady_flow = 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
